### rtl/dddays_pkg.sv
// ----------------------------------------------------------------------------
// dddays_pkg
// Types, constants and per-stage functions for the Gregorian day difference
// pipeline.
// ----------------------------------------------------------------------------
package dddays_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DIFF_W  = 23;
   localparam int DNUM_W  = 23;

   // Configuration register indexes.
   localparam logic [1:0] CSR_REF_YEAR  = 2'd0;
   localparam logic [1:0] CSR_REF_MONTH = 2'd1;
   localparam logic [1:0] CSR_REF_DAY   = 2'd2;

   localparam logic [YEAR_W-1:0]  REF_YEAR_RESET  = 14'd1990;
   localparam logic [MONTH_W-1:0] REF_MONTH_RESET = 4'd1;
   localparam logic [DAY_W-1:0]   REF_DAY_RESET   = 5'd1;

   // Day numbers count from an epoch 400 years before year 1.
   localparam logic [14:0] YEAR_OFFSET = 15'd399;
   // floor(x / 100) == (x * 5243) >> 19 for every x below 2**15.
   localparam logic [27:0] RECIP_100   = 28'd5243;
   localparam logic [15:0] HUNDRED     = 16'd100;
   localparam logic [22:0] DAYS_YEAR   = 23'd365;

   localparam logic [DIFF_W-1:0] DIFF_MAX = 23'h3F_FFFF;
   localparam logic [DIFF_W-1:0] DIFF_MIN = 23'h40_0000;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic              month_gt2;
      logic [8:0]        month_day;   // days before the month plus day of month
      logic [14:0]       n;           // completed years since the epoch
   } s1_type;

   typedef struct packed {
      logic [YEAR_W-1:0] year;
      logic [7:0]        year_q100;
      logic              month_gt2;
      logic [8:0]        month_day;
      logic [22:0]       n365;
      logic [12:0]       n_q4;
      logic [7:0]        n_q100;
      logic [5:0]        n_q400;
   } s2_type;

   typedef struct packed {
      logic        leap_add;
      logic [8:0]  month_day;
      logic [22:0] year_days;
   } s3_type;

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Month saturation, epoch-relative year count and offset within the year.
   function automatic s1_type stage1_f(input date_type dt);
      s1_type            r;
      logic [MONTH_W-1:0] m;
      if (dt.month == 4'd0) begin
         m = 4'd1;
      end else if (dt.month > 4'd12) begin
         m = 4'd12;
      end else begin
         m = dt.month;
      end
      r.year      = dt.year;
      r.month_gt2 = (m > 4'd2);
      r.month_day = days_before_month(m) + 9'(dt.day);
      r.n         = 15'(dt.year) + YEAR_OFFSET;
      return r;
   endfunction

   // Constant multiplications: 365 * n and the quotients by 100 and 400.
   function automatic s2_type stage2_f(input s1_type s);
      s2_type      r;
      logic [27:0] p_y;
      logic [27:0] p_n;
      logic [27:0] p_n4;
      p_y          = 28'(s.year) * RECIP_100;
      p_n          = 28'(s.n) * RECIP_100;
      p_n4         = 28'(s.n[14:2]) * RECIP_100;
      r.year       = s.year;
      r.year_q100  = p_y[26:19];
      r.month_gt2  = s.month_gt2;
      r.month_day  = s.month_day;
      r.n365       = 23'(s.n) * DAYS_YEAR;
      r.n_q4       = s.n[14:2];
      r.n_q100     = p_n[26:19];
      r.n_q400     = p_n4[24:19];
      return r;
   endfunction

   // Leap year test and the day count of all completed years.
   function automatic s3_type stage3_f(input s2_type s);
      s3_type r;
      logic   cent;
      logic   leap;
      cent        = ({2'b00, s.year} == 16'(16'(s.year_q100) * HUNDRED));
      leap        = ((s.year[1:0] == 2'b00) && !cent) ||
                    (cent && (s.year_q100[1:0] == 2'b00));
      r.leap_add  = leap && s.month_gt2;
      r.month_day = s.month_day;
      r.year_days = s.n365 + 23'(s.n_q4) + 23'(s.n_q400) - 23'(s.n_q100);
      return r;
   endfunction

   function automatic logic [DNUM_W-1:0] stage4_f(input s3_type s);
      return s.year_days + 23'(s.month_day) + 23'(s.leap_add);
   endfunction

   // Signed difference of two day numbers, saturated to the result field.
   function automatic logic [DIFF_W-1:0] diff_sat_f(input logic [DNUM_W-1:0] t,
                                                   input logic [DNUM_W-1:0] r);
      logic [DNUM_W:0] d;
      d = {1'b0, t} - {1'b0, r};
      if (d[DNUM_W] != d[DNUM_W-1]) begin
         return d[DNUM_W] ? DIFF_MIN : DIFF_MAX;
      end
      return d[DIFF_W-1:0];
   endfunction

endpackage

### rtl/date_difference_in_days.sv
// ----------------------------------------------------------------------------
// date_difference_in_days
// Signed Gregorian day difference from a configured reference date to each
// streamed target date.
// ----------------------------------------------------------------------------
// Usage:
// Target dates arrive on the req_ stream, one per transfer, and each produces
// exactly one rsp_ transfer holding the signed number of days from the
// reference date to the target (positive when the target is later).
// The reference date sits in three registers written over the csr_ port,
// which is always ready; write them only while no date is in flight.
// The block is a five-stage pipeline: month lookup, constant multiplies,
// leap test and year sum, day number, then difference and saturation into
// the output register. One date is taken every cycle while the receiver
// does not stall.
// The reference date travels down the pipeline beside each target, so a
// register write is seen by every date accepted after it.
// When the receiver stalls, each stage holds its item and a stage only
// refills once it is empty or moving on, so bubbles are squeezed out and
// nothing is lost or repeated. Reset empties the pipeline and restores the
// reference date to 1990-01-01.
// ----------------------------------------------------------------------------
module date_difference_in_days
   import dddays_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Target date stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // target_year[13:0], target_month[17:14],
                                   // target_day[22:18], zero[23]
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // day_difference[22:0], zero[23]
   // Configuration write port.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_data
);

   // Reference date registers.
   logic [YEAR_W-1:0]  ref_year_ff,  ref_year_in;
   logic [MONTH_W-1:0] ref_month_ff, ref_month_in;
   logic [DAY_W-1:0]   ref_day_ff,   ref_day_in;

   // Stage valid bits.
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in, v5_ff, v5_in;
   // A stage may load when it is empty or its content moves on this cycle.
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   // Lane 0 carries the target date, lane 1 the reference date.
   s1_type            s1_ff [2];
   s1_type            s1_in [2];
   s2_type            s2_ff [2];
   s2_type            s2_in [2];
   s3_type            s3_ff [2];
   s3_type            s3_in [2];
   logic [DNUM_W-1:0] s4_ff [2];
   logic [DNUM_W-1:0] s4_in [2];
   logic [DIFF_W-1:0] s5_ff, s5_in;

   date_type target_date;
   date_type ref_date;

   assign csr_ready = 1'b1;

   // Configuration writes; an index beyond the list is ignored.
   always_comb begin
      ref_year_in  = ref_year_ff;
      ref_month_in = ref_month_ff;
      ref_day_in   = ref_day_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REF_YEAR:  ref_year_in  = csr_data;
            CSR_REF_MONTH: ref_month_in = csr_data[MONTH_W-1:0];
            CSR_REF_DAY:   ref_day_in   = csr_data[DAY_W-1:0];
            default:       ref_year_in  = ref_year_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_year_ff  <= REF_YEAR_RESET;
         ref_month_ff <= REF_MONTH_RESET;
         ref_day_ff   <= REF_DAY_RESET;
      end else begin
         ref_year_ff  <= ref_year_in;
         ref_month_ff <= ref_month_in;
         ref_day_ff   <= ref_day_in;
      end
   end

   // Backpressure chain from the output register to the input.
   assign rdy5 = !v5_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign target_date.year  = req_tdata[13:0];
   assign target_date.month = req_tdata[17:14];
   assign target_date.day   = req_tdata[22:18];
   assign ref_date.year     = ref_year_ff;
   assign ref_date.month    = ref_month_ff;
   assign ref_date.day      = ref_day_ff;

   always_comb begin
      v1_in = rdy1 ? req_tvalid : v1_ff;
      v2_in = rdy2 ? v1_ff      : v2_ff;
      v3_in = rdy3 ? v2_ff      : v3_ff;
      v4_in = rdy4 ? v3_ff      : v4_ff;
      v5_in = rdy5 ? v4_ff      : v5_ff;

      s1_in[0] = rdy1 ? stage1_f(target_date) : s1_ff[0];
      s1_in[1] = rdy1 ? stage1_f(ref_date)    : s1_ff[1];
      for (int i = 0; i < 2; i++) begin
         s2_in[i] = rdy2 ? stage2_f(s1_ff[i]) : s2_ff[i];
         s3_in[i] = rdy3 ? stage3_f(s2_ff[i]) : s3_ff[i];
         s4_in[i] = rdy4 ? stage4_f(s3_ff[i]) : s4_ff[i];
      end
      s5_in = rdy5 ? diff_sat_f(s4_ff[0], s4_ff[1]) : s5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // Payload registers need no reset; the valid bits qualify them.
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
      s5_ff <= s5_in;
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {1'b0, s5_ff};

endmodule
